[rtl/core/weighted_xor_word_checksum_macros.svh]
// ----------------------------------------------------------------------------
// weighted xor word checksum assertion macros
// shared concurrent check forms, clocked on i_clk and held off in reset
// ----------------------------------------------------------------------------
`ifndef WEIGHTED_XOR_WORD_CHECKSUM_MACROS_SVH
`define WEIGHTED_XOR_WORD_CHECKSUM_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define WXC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("wxc check failed: same-cycle rule");

// consequent must hold in the cycle after the antecedent
`define WXC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("wxc check failed: next-cycle rule");

`endif

[rtl/core/wxc_pkg.sv]
// ----------------------------------------------------------------------------
// wxc_pkg
// types and constants shared by the weighted xor word checksum modules
// ----------------------------------------------------------------------------
package wxc_pkg;

    localparam int WORD_W    = 32;
    localparam int BYTE_W    = 8;
    localparam int PART_W    = 24;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_SEED     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_0 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_1 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_2 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_3 = 3'd4;

    localparam logic [WORD_W-1:0] SEED_RESET = 32'hDEAD_BEEF;
    localparam int REG_WEIGHTS = 4;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    // one unit of work for the back end
    typedef struct packed {
        logic              start;  // load the seed before this op
        logic              fold;   // multiply word by weight and fold it in
        logic              emit;   // deliver the accumulator and close
        logic [WORD_W-1:0] word;
    } t_op;

    typedef struct packed {
        logic              full;
        logic              empty;
        logic [QCNT_W-1:0] count;
    } t_q_stat;

endpackage

[rtl/core/wxc_front.sv]
// ----------------------------------------------------------------------------
// wxc_front
// accepts message bytes, packs them little-endian into words and issues
// fold and close operations to the queue
// ----------------------------------------------------------------------------
module wxc_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_fire,
    input  logic [wxc_pkg::BYTE_W-1:0] i_byte,
    input  logic                       i_present,
    input  logic                       i_last,
    output logic                       o_push,
    output wxc_pkg::t_op               o_op
);
    import wxc_pkg::*;

    logic              r_in_msg, n_in_msg;
    logic              r_pend, n_pend;
    logic [1:0]        r_pos, n_pos;
    logic [PART_W-1:0] r_part, n_part;

    logic              full_word;
    logic              in_after;
    logic              start_flag;
    logic [PART_W-1:0] part_after;
    logic [1:0]        pos_after;

    always_comb begin
        full_word  = i_present && (r_pos == 2'd3);
        in_after   = r_in_msg || i_present;
        // first op of a message carries the seed load
        start_flag = r_in_msg ? r_pend : 1'b1;
        part_after = r_part;
        pos_after  = r_pos;
        if (full_word) begin
            part_after = '0;
            pos_after  = 2'd0;
        end else if (i_present) begin
            part_after = r_part | (PART_W'(i_byte) << {r_pos, 3'b000});
            pos_after  = r_pos + 2'd1;
        end

        o_push     = i_fire && (full_word || i_last);
        o_op.start = start_flag;
        o_op.fold  = full_word || (i_last && (pos_after != 2'd0));
        o_op.emit  = i_last;
        o_op.word  = full_word ? {i_byte, r_part} : {8'h00, part_after};

        n_in_msg = r_in_msg;
        n_pend   = r_pend;
        n_pos    = r_pos;
        n_part   = r_part;
        if (i_fire) begin
            if (i_last) begin
                n_in_msg = 1'b0;
                n_pend   = 1'b0;
                n_pos    = 2'd0;
                n_part   = '0;
            end else begin
                n_in_msg = in_after;
                n_pend   = in_after && start_flag && !o_push;
                n_pos    = pos_after;
                n_part   = part_after;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_msg <= 1'b0;
            r_pend   <= 1'b0;
            r_pos    <= 2'd0;
            r_part   <= '0;
        end else begin
            r_in_msg <= n_in_msg;
            r_pend   <= n_pend;
            r_pos    <= n_pos;
            r_part   <= n_part;
        end
    end

endmodule

[rtl/core/wxc_fifo.sv]
// ----------------------------------------------------------------------------
// wxc_fifo
// short operation queue between the front and back ends
// ----------------------------------------------------------------------------
module wxc_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  wxc_pkg::t_op     i_op,
    input  logic             i_pop,
    output wxc_pkg::t_op     o_op,
    output wxc_pkg::t_q_stat o_stat
);
    import wxc_pkg::*;

    t_op               r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr, r_rd;
    logic [QCNT_W-1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + QPTR_W'(1);
            end
            unique case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + QCNT_W'(1);
                2'b01:   r_cnt <= r_cnt - QCNT_W'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    assign o_op         = r_mem[r_rd];
    assign o_stat.full  = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign o_stat.count = r_cnt;

endmodule

[rtl/core/wxc_back.sv]
// ----------------------------------------------------------------------------
// wxc_back
// configuration registers, weight rotation, multiplier stage and the
// accumulator with its output register
// ----------------------------------------------------------------------------
module wxc_back #(
    parameter int WEIGHT_COUNT = 4
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [wxc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [wxc_pkg::WORD_W-1:0]    i_cfg_wdata,
    input  wxc_pkg::t_op                  i_op,
    input  logic                          i_q_empty,
    output logic                          o_pop,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [wxc_pkg::WORD_W-1:0]    o_m_tdata
);
    import wxc_pkg::*;

    localparam int WIDX_W = (WEIGHT_COUNT > 1) ? $clog2(WEIGHT_COUNT) : 1;

    logic [WORD_W-1:0] r_seed;
    logic [WORD_W-1:0] r_weight [REG_WEIGHTS];
    logic [WIDX_W-1:0] r_widx, n_widx;

    logic              r_m_valid;
    logic              r_m_start, r_m_fold, r_m_emit;
    logic [WORD_W-1:0] r_m_prod;
    logic [WORD_W-1:0] r_acc;
    logic              r_o_valid;
    logic [WORD_W-1:0] r_o_data;

    logic [2:0]          widx3;
    logic [WORD_W-1:0]   weight;
    logic [WORD_W-1:0]   prod;
    logic                stall;
    logic                adv;
    logic [WORD_W-1:0]   base;
    logic [WORD_W-1:0]   folded;

    always_comb begin
        widx3 = 3'(r_widx);
        // indexes past the register set use a fixed weight
        if (widx3 < 3'd4) begin
            weight = r_weight[widx3[1:0]];
        end else begin
            weight = WORD_W'(widx3) + WORD_W'(1);
        end
        // only the low word of the product is folded in
        prod = i_op.word * weight;

        stall = r_m_valid && r_m_emit && r_o_valid && !i_m_tready;
        adv   = r_m_valid && !stall;
        o_pop = !i_q_empty && !stall;

        n_widx = r_widx;
        if (i_op.fold) begin
            n_widx = (r_widx == WIDX_W'(WEIGHT_COUNT - 1)) ? '0 : r_widx + WIDX_W'(1);
        end
        if (i_op.emit) begin
            n_widx = '0;
        end

        base   = r_m_start ? r_seed : r_acc;
        folded = r_m_fold ? (base ^ r_m_prod) : base;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed      <= SEED_RESET;
            r_weight[0] <= WORD_W'(1);
            r_weight[1] <= WORD_W'(2);
            r_weight[2] <= WORD_W'(3);
            r_weight[3] <= WORD_W'(4);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SEED:     r_seed      <= i_cfg_wdata;
                CFG_WEIGHT_0: r_weight[0] <= i_cfg_wdata;
                CFG_WEIGHT_1: r_weight[1] <= i_cfg_wdata;
                CFG_WEIGHT_2: r_weight[2] <= i_cfg_wdata;
                CFG_WEIGHT_3: r_weight[3] <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_widx    <= '0;
            r_m_valid <= 1'b0;
            r_o_valid <= 1'b0;
            r_acc     <= '0;
        end else begin
            if (!stall) begin
                r_m_valid <= o_pop;
            end
            if (o_pop) begin
                r_widx <= n_widx;
            end
            if (adv && r_m_emit) begin
                r_o_valid <= 1'b1;
            end else if (r_o_valid && i_m_tready) begin
                r_o_valid <= 1'b0;
            end
            if (adv) begin
                if (r_m_emit) begin
                    r_acc <= '0;
                end else begin
                    r_acc <= folded;
                end
            end
        end
    end

    // multiplier stage and output payload
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_m_start <= i_op.start;
            r_m_fold  <= i_op.fold;
            r_m_emit  <= i_op.emit;
            r_m_prod  <= prod;
        end
        if (adv && r_m_emit) begin
            r_o_data <= folded;
        end
    end

    assign o_m_tvalid = r_o_valid;
    assign o_m_tdata  = r_o_data;

endmodule

[rtl/core/weighted_xor_word_checksum.sv]
// ----------------------------------------------------------------------------
// weighted_xor_word_checksum
// byte stream in, one weighted xor word checksum out per message
// ----------------------------------------------------------------------------
// One byte beat per cycle while the queue has room; no gaps between messages.
// Bytes pack little-endian into 32-bit words; each word is multiplied by a
// rotating weight and xored into an accumulator seeded from the seed
// register. A beat with tlast closes the message; a tlast beat with no byte
// and no open message returns the seed. With an empty queue the checksum
// beat follows the closing beat through the queue entry, the multiplier stage,
// then accumulator and output register; ops already waiting in the queue or
// a stalled output hold it back. A four-entry queue separates the byte packer
// from the multiplier path, so bytes keep flowing for a while when a result
// waits on the output. Configuration writes take effect at once and are
// meant for quiet periods; the seed is sampled when a message's first op
// reaches the accumulator.
module weighted_xor_word_checksum #(
    parameter int WEIGHT_COUNT = 4
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [7:0]                    i_s_tdata,   // [7:0] data_byte
    input  logic                          i_s_tuser,   // [0] byte_present
    input  logic                          i_s_tlast,   // last_item
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [31:0]                   o_m_tdata,   // [31:0] checksum
    input  logic                          i_cfg_we,
    input  logic [wxc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [31:0]                   i_cfg_wdata
);
    import wxc_pkg::*;

    `include "weighted_xor_word_checksum_macros.svh"

    logic    s_fire;
    logic    q_push;
    logic    q_pop;
    t_op     f_op;
    t_op     q_op;
    t_q_stat q_stat;

    assign o_s_tready = !q_stat.full;
    assign s_fire     = i_s_tvalid && o_s_tready;

    wxc_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (s_fire),
        .i_byte    (i_s_tdata),
        .i_present (i_s_tuser),
        .i_last    (i_s_tlast),
        .o_push    (q_push),
        .o_op      (f_op)
    );

    wxc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_op    (f_op),
        .i_pop   (q_pop),
        .o_op    (q_op),
        .o_stat  (q_stat)
    );

    wxc_back #(
        .WEIGHT_COUNT (WEIGHT_COUNT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_op        (q_op),
        .i_q_empty   (q_stat.empty),
        .o_pop       (q_pop),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

    // every closing beat must turn into a queued close op
    `WXC_ASSERT_NOW(a_last_pushes, s_fire && i_s_tlast, q_push && f_op.emit)
    // a beat without byte or close leaves the queue alone
    `WXC_ASSERT_NOW(a_idle_no_push, s_fire && !i_s_tuser && !i_s_tlast, !q_push)
    `WXC_ASSERT_NOW(a_pop_nonempty, q_pop, !q_stat.empty)
    `WXC_ASSERT_NEXT(a_count_up, q_push && !q_pop,
                     q_stat.count == $past(q_stat.count) + QCNT_W'(1))

endmodule
